// File: design/wsfr_pkg.sv
// Package for the websocket frame receiver: result kinds, opcodes and
// header constants shared by the result channel interface and the receiver.
// No dependencies.
package wsfr_pkg;

	localparam int MAX_LENGTH_BITS_DEF = 24;

	typedef enum logic [2:0] {
		K_DATA       = 3'd0,
		K_PING       = 3'd1,
		K_EMPTY_PING = 3'd2,
		K_CLOSE      = 3'd3,
		K_OVERSIZE   = 3'd4,
		K_REJECT     = 3'd5
	} kind_t;

	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

// File: design/wsfr_byte_if.sv
// Byte channel into the receiver: valid/ready with one stream byte per beat.
// No dependencies.
interface wsfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: design/wsfr_result_if.sv
// Result channel out of the receiver: valid/ready with one result per beat.
// Depends on wsfr_pkg for the result kind type.
interface wsfr_result_if;
	wsfr_pkg::kind_t kind;
	logic            valid;
	logic            ready;
	logic [7:0]      payload_byte;
	logic            last_of_frame;

	modport source (output valid, output kind, output payload_byte, output last_of_frame,
		input ready);
	modport sink (input valid, input kind, input payload_byte, input last_of_frame,
		output ready);
endinterface

// File: design/websocket_frame_receiver_unit.sv
// WebSocket frame receiver: header parse, length check, unmasking, result kinds.
// A byte accepted into the input register gives its result (if any) in the result register.
// Takes one byte per cycle while the result channel does not stall (result valid, ready low).
// Reset (arst_n low, asynchronous): parser waits for a first header byte, close and
// error flags clear, max_frame_bytes returns to 1 << MAX_LENGTH_BITS.
// Depends on wsfr_pkg, wsfr_byte_if and wsfr_result_if.
module websocket_frame_receiver_unit #(
	parameter int MAX_LENGTH_BITS = wsfr_pkg::MAX_LENGTH_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [MAX_LENGTH_BITS:0]   cfg_wdata,
	wsfr_byte_if.sink                  stream,
	wsfr_result_if.source              result
);
	import wsfr_pkg::*;

	localparam int LW = MAX_LENGTH_BITS + 1;

	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASKKEY = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_HALT    = 3'd5
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [3:0]      op_q, op_d;
	logic            mask_q, mask_d;
	logic [LW-1:0]   acc_q, acc_d;
	logic            acc_hi_q, acc_hi_d;
	logic [3:0]      left_q, left_d;
	logic [31:0]     key_q, key_d;
	logic [LW-1:0]   remain_q, remain_d;
	logic [1:0]      pos_q, pos_d;
	logic            closed_q, closed_d;
	logic            failed_q, failed_d;
	logic [LW-1:0]   max_q;

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            advance;

	logic            emit;
	kind_t           kind_d;
	logic [7:0]      data_d;
	logic            last_d;
	logic            len_done;
	logic            start_pl;
	logic [6:0]      code;
	logic [7:0]      key_byte;
	logic            pl_last;

	logic            res_valid_q;
	kind_t           res_kind_q;
	logic [7:0]      res_byte_q;
	logic            res_last_q;

	assign advance      = valid_s1 && (!res_valid_q || result.ready);
	assign stream.ready = !valid_s1 || advance;

	assign result.valid         = res_valid_q;
	assign result.kind          = res_kind_q;
	assign result.payload_byte  = res_byte_q;
	assign result.last_of_frame = res_last_q;

	assign code = byte_s1[6:0];

	always_comb begin
		unique case (pos_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			2'd3: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		op_d     = op_q;
		mask_d   = mask_q;
		acc_d    = acc_q;
		acc_hi_d = acc_hi_q;
		left_d   = left_q;
		key_d    = key_q;
		remain_d = remain_q;
		pos_d    = pos_q;
		closed_d = closed_q;
		failed_d = failed_q;
		emit     = 1'b0;
		kind_d   = K_DATA;
		data_d   = '0;
		last_d   = 1'b0;
		len_done = 1'b0;
		start_pl = 1'b0;
		pl_last  = 1'b0;

		if (closed_q || failed_q) begin
			emit   = 1'b1;
			kind_d = K_REJECT;
		end else begin
			unique case (phase_q)
				PH_HDR1: begin
					mask_d   = byte_s1[7];
					acc_d    = '0;
					acc_hi_d = 1'b0;
					if (code == LEN_CODE_16) begin
						left_d  = EXT16_BYTES;
						phase_d = PH_EXTLEN;
					end else if (code == LEN_CODE_64) begin
						left_d  = EXT64_BYTES;
						phase_d = PH_EXTLEN;
					end else begin
						acc_d    = {{(LW-7){1'b0}}, code};
						len_done = 1'b1;
					end
				end
				PH_EXTLEN: begin
					acc_d    = {acc_q[LW-9:0], byte_s1};
					acc_hi_d = acc_hi_q | (|acc_q[LW-1:LW-8]);
					left_d   = left_q - 4'd1;
					len_done = (left_q == 4'd1);
				end
				PH_MASKKEY: begin
					key_d    = {key_q[23:0], byte_s1};
					left_d   = left_q - 4'd1;
					start_pl = (left_q == 4'd1);
				end
				PH_PAYLOAD: begin
					pos_d    = pos_q + 2'd1;
					remain_d = remain_q - {{(LW-1){1'b0}}, 1'b1};
					pl_last  = (remain_q == {{(LW-1){1'b0}}, 1'b1});
					if (pl_last) begin
						phase_d = PH_HDR0;
					end
					if (op_q == OP_BIN || op_q == OP_CONT) begin
						emit   = 1'b1;
						kind_d = K_DATA;
						data_d = byte_s1 ^ (mask_q ? key_byte : 8'h00);
						last_d = pl_last;
					end else if (op_q == OP_PING) begin
						emit   = 1'b1;
						kind_d = K_PING;
						data_d = byte_s1 ^ (mask_q ? key_byte : 8'h00);
						last_d = pl_last;
					end else if (op_q == OP_CLOSE && pl_last) begin
						emit     = 1'b1;
						kind_d   = K_CLOSE;
						last_d   = 1'b1;
						closed_d = 1'b1;
						phase_d  = PH_HALT;
					end
				end
				default: begin
					op_d    = byte_s1[3:0];
					phase_d = PH_HDR1;
				end
			endcase

			if (len_done) begin
				if (acc_hi_d || (acc_d > max_q)) begin
					failed_d = 1'b1;
					phase_d  = PH_HALT;
					emit     = 1'b1;
					kind_d   = K_OVERSIZE;
					last_d   = 1'b1;
				end else begin
					remain_d = acc_d;
					if (mask_d) begin
						key_d   = '0;
						left_d  = KEY_BYTES;
						phase_d = PH_MASKKEY;
					end else begin
						start_pl = 1'b1;
					end
				end
			end

			if (start_pl) begin
				pos_d = '0;
				if (remain_d != '0) begin
					phase_d = PH_PAYLOAD;
				end else if (op_q == OP_CLOSE) begin
					closed_d = 1'b1;
					phase_d  = PH_HALT;
					emit     = 1'b1;
					kind_d   = K_CLOSE;
					last_d   = 1'b1;
				end else begin
					phase_d = PH_HDR0;
					if (op_q == OP_PING) begin
						emit   = 1'b1;
						kind_d = K_EMPTY_PING;
						last_d = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			op_q        <= '0;
			mask_q      <= 1'b0;
			acc_q       <= '0;
			acc_hi_q    <= 1'b0;
			left_q      <= '0;
			key_q       <= '0;
			remain_q    <= '0;
			pos_q       <= '0;
			closed_q    <= 1'b0;
			failed_q    <= 1'b0;
			max_q       <= {1'b1, {(LW-1){1'b0}}};
			valid_s1    <= 1'b0;
			byte_s1     <= '0;
			res_valid_q <= 1'b0;
			res_kind_q  <= K_DATA;
			res_byte_q  <= '0;
			res_last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (stream.ready) begin
				valid_s1 <= stream.valid;
				byte_s1  <= stream.rx_byte;
			end
			if (advance) begin
				phase_q     <= phase_d;
				op_q        <= op_d;
				mask_q      <= mask_d;
				acc_q       <= acc_d;
				acc_hi_q    <= acc_hi_d;
				left_q      <= left_d;
				key_q       <= key_d;
				remain_q    <= remain_d;
				pos_q       <= pos_d;
				closed_q    <= closed_d;
				failed_q    <= failed_d;
				res_valid_q <= emit;
				if (emit) begin
					res_kind_q  <= kind_d;
					res_byte_q  <= data_d;
					res_last_q  <= last_d;
				end
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	a_failed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q)
		else $error("stream error flag cleared");

	a_close_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_kind_q == K_CLOSE) |-> closed_q)
		else $error("close reported without closed flag");

	a_payload_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (remain_q != '0))
		else $error("payload phase with nothing remaining");

	a_halt_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(closed_q && failed_q))
		else $error("closed and failed both set");

endmodule
